>>> rtl/core/tpcs_pkg.sv
// Shared constants and types for the two-piston cycle sequencer.
// Used by two_piston_cycle_sequencer_core and its port checker; no dependencies.
`default_nettype none

package tpcs_pkg;

  localparam int unsigned TimerBitsDef  = 16;
  localparam int unsigned SensorBitsDef = 10;

  localparam int unsigned TimeoutRst   = 15000;
  localparam int unsigned ThresholdRst = 288;

  // Sequencer phase codes
  localparam logic [1:0] PhIdle    = 2'd0;
  localparam logic [1:0] PhRetract = 2'd1;
  localparam logic [1:0] PhFeedExt = 2'd2;
  localparam logic [1:0] PhPackExt = 2'd3;

  // Command codes carried in the input tuser
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdInit  = 2'd2;

  // Outcome codes
  localparam logic [1:0] OutNone    = 2'd0;
  localparam logic [1:0] OutSuccess = 2'd1;
  localparam logic [1:0] OutStopped = 2'd2;
  localparam logic [1:0] OutTimeout = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] RegTimeout   = 2'd0;
  localparam logic [1:0] RegThreshold = 2'd1;
  localparam logic [1:0] RegRetInit   = 2'd2;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned OutDataW = 16;

  typedef struct packed {
    logic recycle;
    logic pack_ret;
    logic pack_ext;
    logic feed_ret;
    logic feed_ext;
  } relay_t;

endpackage

`default_nettype wire

>>> rtl/core/two_piston_cycle_sequencer_core.sv
// Two-piston cycle sequencer: relay sequencing of a feed and a packing piston.
// Depends on tpcs_pkg for codes, defaults and the relay struct.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+-------------------------------------
//  s_axis   | in        | s_axis_tvalid_i/tready_o   | tuser: command; tdata: levels, key
//  m_axis   | out       | m_axis_tvalid_o/tready_i   | tdata: relays, busy, phase, outcome
//  cfg      | in        | cfg_valid_i/cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One item per clock cycle sustained while m_axis_tready_i is not held low; a result
// passes through the input register, then the result register. The sequencer state
// updates in one pass of compares and a timer decrement as the item moves from
// the input register into the result register. While a result waits, the input
// register takes one more transaction and then holds tready low. Reset clears
// the state and loads the register defaults; the configuration port is always ready.
`default_nettype none

module two_piston_cycle_sequencer_core #(
  parameter int unsigned TIMER_BITS  = tpcs_pkg::TimerBitsDef,
  parameter int unsigned SENSOR_BITS = tpcs_pkg::SensorBitsDef,
  localparam int unsigned InFieldW = 4 * SENSOR_BITS + 1,
  localparam int unsigned InDataW  = ((InFieldW + 7) / 8) * 8,
  localparam int unsigned CfgDataW = (TIMER_BITS > SENSOR_BITS) ? TIMER_BITS : SENSOR_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // tuser: command[1:0]
  input  wire logic [1:0]                   s_axis_tuser_i,
  // tdata: feed_out_level, feed_in_level, pack_out_level, pack_in_level, key_click, pad
  input  wire logic [InDataW-1:0]           s_axis_tdata_i,
  input  wire logic                         s_axis_tvalid_i,
  output      logic                         s_axis_tready_o,
  // tdata: feed_extend_drive, feed_retract_drive, pack_extend_drive,
  //        pack_retract_drive, recycle_drive, busy_res, current_phase[1:0],
  //        outcome[1:0], pad
  output      logic [tpcs_pkg::OutDataW-1:0] m_axis_tdata_o,
  output      logic                         m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [tpcs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]          cfg_data_i
);

  localparam int unsigned SB = SENSOR_BITS;

  // Configuration registers
  logic [TIMER_BITS-1:0]  timeout_q;
  logic [SENSOR_BITS-1:0] threshold_q;
  logic                   ret_init_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q   <= TIMER_BITS'(tpcs_pkg::TimeoutRst);
      threshold_q <= SENSOR_BITS'(tpcs_pkg::ThresholdRst);
      ret_init_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tpcs_pkg::RegTimeout:   timeout_q   <= cfg_data_i[TIMER_BITS-1:0];
        tpcs_pkg::RegThreshold: threshold_q <= cfg_data_i[SENSOR_BITS-1:0];
        tpcs_pkg::RegRetInit:   ret_init_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                   in_valid_q;
  logic [1:0]             cmd_q;
  logic [InFieldW-1:0]    in_data_q;
  logic                   advance;

  assign advance         = in_valid_q && (!m_axis_tvalid_o || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q     <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i[InFieldW-1:0];
    end
  end

  logic [SB-1:0] feed_out_lvl, feed_in_lvl, pack_out_lvl, pack_in_lvl;
  logic          key_click;

  assign feed_out_lvl = in_data_q[SB-1:0];
  assign feed_in_lvl  = in_data_q[2*SB-1:SB];
  assign pack_out_lvl = in_data_q[3*SB-1:2*SB];
  assign pack_in_lvl  = in_data_q[4*SB-1:3*SB];
  assign key_click    = in_data_q[4*SB];

  // Sequencer state
  logic [1:0]            phase_q, phase_d;
  logic                  init_mode_q, init_mode_d;
  logic [TIMER_BITS-1:0] ticks_q, ticks_d;
  logic                  feed_seen_q, feed_seen_d;
  logic                  pack_seen_q, pack_seen_d;
  tpcs_pkg::relay_t      relay_q, relay_d;
  logic [1:0]            outcome;

  logic                  enter;
  logic [1:0]            enter_phase;
  logic                  done;
  logic                  feed_home, pack_home;

  assign feed_home = feed_seen_q || (feed_in_lvl > threshold_q);
  assign pack_home = pack_seen_q || (pack_in_lvl > threshold_q);

  always_comb begin
    phase_d     = phase_q;
    init_mode_d = init_mode_q;
    ticks_d     = ticks_q;
    feed_seen_d = feed_seen_q;
    pack_seen_d = pack_seen_q;
    relay_d     = relay_q;
    outcome     = tpcs_pkg::OutNone;
    enter       = 1'b0;
    enter_phase = tpcs_pkg::PhRetract;
    done        = 1'b0;

    if (phase_q == tpcs_pkg::PhIdle) begin
      if (cmd_q == tpcs_pkg::CmdStart) begin
        relay_d.recycle = 1'b0;
        init_mode_d     = 1'b0;
        enter           = 1'b1;
      end else if (cmd_q == tpcs_pkg::CmdInit) begin
        if (ret_init_q) begin
          relay_d.recycle = 1'b0;
          init_mode_d     = 1'b1;
          enter           = 1'b1;
        end else begin
          outcome = tpcs_pkg::OutSuccess;
        end
      end
    end else begin
      unique case (phase_q)
        tpcs_pkg::PhRetract: begin
          feed_seen_d = feed_home;
          pack_seen_d = pack_home;
          done        = feed_home && pack_home;
        end
        tpcs_pkg::PhFeedExt: done = feed_out_lvl > threshold_q;
        default:             done = pack_out_lvl > threshold_q;
      endcase

      if (done) begin
        if (phase_q == tpcs_pkg::PhRetract && init_mode_q) begin
          outcome = tpcs_pkg::OutSuccess;
        end else begin
          enter = 1'b1;
          // wrap from the packing stroke back to the retract phase
          enter_phase = (phase_q == tpcs_pkg::PhPackExt) ? tpcs_pkg::PhRetract
                                                         : phase_q + 2'd1;
        end
      end else if (key_click) begin
        outcome = tpcs_pkg::OutStopped;
      end else if (ticks_q <= TIMER_BITS'(1)) begin
        ticks_d = '0;
        outcome = tpcs_pkg::OutTimeout;
      end else begin
        ticks_d = ticks_q - TIMER_BITS'(1);
      end

      // finish on success of init, stop or timeout
      if (outcome != tpcs_pkg::OutNone) begin
        relay_d.feed_ext = 1'b0;
        relay_d.feed_ret = 1'b0;
        relay_d.pack_ext = 1'b0;
        relay_d.pack_ret = 1'b0;
        relay_d.recycle  = 1'b1;
        phase_d          = tpcs_pkg::PhIdle;
        init_mode_d      = 1'b0;
      end
    end

    if (enter) begin
      phase_d          = enter_phase;
      ticks_d          = timeout_q;
      relay_d.feed_ext = (enter_phase == tpcs_pkg::PhFeedExt);
      relay_d.feed_ret = (enter_phase == tpcs_pkg::PhRetract);
      relay_d.pack_ext = (enter_phase == tpcs_pkg::PhPackExt);
      relay_d.pack_ret = (enter_phase == tpcs_pkg::PhRetract);
      if (enter_phase == tpcs_pkg::PhRetract) begin
        feed_seen_d = 1'b0;
        pack_seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tpcs_pkg::PhIdle;
      init_mode_q <= 1'b0;
      ticks_q     <= '0;
      feed_seen_q <= 1'b0;
      pack_seen_q <= 1'b0;
      relay_q     <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      init_mode_q <= init_mode_d;
      ticks_q     <= ticks_d;
      feed_seen_q <= feed_seen_d;
      pack_seen_q <= pack_seen_d;
      relay_q     <= relay_d;
    end
  end

  // Result register
  logic [tpcs_pkg::OutDataW-1:0] res_data_d;

  assign res_data_d = {6'b0, outcome, phase_d, (phase_d != tpcs_pkg::PhIdle),
                       relay_d.recycle, relay_d.pack_ret, relay_d.pack_ext,
                       relay_d.feed_ret, relay_d.feed_ext};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid_o <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid_o <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_axis_tvalid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      m_axis_tdata_o <= res_data_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/tpcs_port_checker.sv
// Port-level checks for two_piston_cycle_sequencer_core, with its bind.
// Depends on tpcs_pkg for phase and outcome codes.
`default_nettype none

module tpcs_port_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic [tpcs_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i
);

  logic       busy, recycle, feed_ext, feed_ret, pack_ext, pack_ret;
  logic [1:0] phase, outcome;

  assign feed_ext = m_axis_tdata_o[0];
  assign feed_ret = m_axis_tdata_o[1];
  assign pack_ext = m_axis_tdata_o[2];
  assign pack_ret = m_axis_tdata_o[3];
  assign recycle  = m_axis_tdata_o[4];
  assign busy     = m_axis_tdata_o[5];
  assign phase    = m_axis_tdata_o[7:6];
  assign outcome  = m_axis_tdata_o[9:8];

  // a reported outcome always leaves the sequencer idle
  a_outcome_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && outcome != tpcs_pkg::OutNone |-> !busy && phase == tpcs_pkg::PhIdle)
    else $error("outcome reported while busy");

  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> busy == (phase != tpcs_pkg::PhIdle))
    else $error("busy flag disagrees with phase");

  // during a cycle recirculation is off and exactly one stroke pattern is driven
  a_busy_relays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && busy |-> !recycle &&
      ((phase == tpcs_pkg::PhRetract && feed_ret && pack_ret && !feed_ext && !pack_ext) ||
       (phase == tpcs_pkg::PhFeedExt && feed_ext && !feed_ret && !pack_ext && !pack_ret) ||
       (phase == tpcs_pkg::PhPackExt && pack_ext && !feed_ret && !feed_ext && !pack_ret)))
    else $error("relay pattern does not match phase");

  a_idle_pistons_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !busy |-> !feed_ext && !feed_ret && !pack_ext && !pack_ret)
    else $error("piston relay on while idle");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind two_piston_cycle_sequencer_core tpcs_port_checker u_tpcs_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i)
);

`default_nettype wire
